// File: design/i2cms_pkg.sv
// Shared types, codes and constants for the I2C master transfer sequencer.
package i2cms_pkg;

   localparam int LEN_BITS_DEFAULT = 16;
   localparam int REQ_TDATA_W      = 48;
   localparam int REQ_TUSER_W      = 2;
   localparam int RSP_TDATA_W      = 48;

   typedef enum logic [1:0] {
      ACT_POLL  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      TOP_INIT  = 4'b0001,
      TOP_IDLE  = 4'b0010,
      TOP_WRITE = 4'b0100,
      TOP_READ  = 4'b1000
   } top_phase_type;

   typedef enum logic [5:0] {
      SUB_IDLE  = 6'b000001,
      SUB_START = 6'b000010,
      SUB_ADDR  = 6'b000100,
      SUB_CHECK = 6'b001000,
      SUB_DATA  = 6'b010000,
      SUB_WAIT  = 6'b100000
   } sub_phase_type;

   typedef enum logic [1:0] {
      STAT_IDLE = 2'd0,
      STAT_BUSY = 2'd1,
      STAT_OK   = 2'd2,
      STAT_ERR  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ACK_KEEP    = 2'd0,
      ACK_ENABLE  = 2'd1,
      ACK_DISABLE = 2'd2
   } ack_ctrl_type;

   localparam logic [7:0] READ_BIT = 8'h01;

   typedef struct packed {
      action_type  action;
      logic [7:0]  target_addr;
      logic [15:0] xfer_length;
      logic        start_flag;
      logic        addr_flag;
      logic        nack_flag;
      logic        tx_empty;
      logic        rx_ready;
      logic [7:0]  rx_data;
      logic [7:0]  tx_byte;
   } req_item_type;

   typedef struct packed {
      logic         accepted;
      status_type   status;
      ack_ctrl_type ack_ctrl;
      logic         gen_start;
      logic         gen_stop;
      logic         write_valid;
      logic [7:0]   write_byte;
      logic         clear_nack;
      logic         clear_addr;
      logic         store_valid;
      logic [7:0]   store_byte;
      logic [15:0]  byte_pos;
   } rsp_item_type;

endpackage

// File: design/i2c_master_transfer_sequencer_top.sv
// Top level of the I2C master transfer sequencer.
//
//   Channel   Direction   Handshake              Payload
//   req_      in          req_tvalid/req_tready  req_tdata, req_tuser (action)
//   rsp_      out         rsp_tvalid/rsp_tready  rsp_tdata
//
// Every transaction yields exactly one response, which passes through the input register
// and then the result register; rsp_tvalid presents it once the result register is free.
// One transaction is taken per cycle as long as the response side keeps up.
// The input register and the result register each hold one transaction.
// Reset returns the sequencer to its initial phase, which the first poll leaves.
// A stalled response holds the result register and, once the input register is full,
// holds req_tready low.
module i2c_master_transfer_sequencer_top #(
   parameter int LEN_BITS = i2cms_pkg::LEN_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // target_addr[7:0], xfer_length[23:8], start_flag[24], addr_flag[25],
   // nack_flag[26], tx_empty[27], rx_ready[28], rx_data[36:29], tx_byte[44:37]
   input  logic [i2cms_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [i2cms_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted[0], status[2:1], ack_ctrl[4:3], gen_start[5], gen_stop[6],
   // write_valid[7], write_byte[15:8], clear_nack[16], clear_addr[17],
   // store_valid[18], store_byte[26:19], byte_pos[42:27]
   output logic [i2cms_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import i2cms_pkg::*;

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         slot_free;
   logic         step;

   assign step = item_valid && slot_free;

   i2cms_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   i2cms_seq_core #(
      .LEN_BITS (LEN_BITS)
   ) u_seq_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item),
      .result (result)
   );

   i2cms_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: design/i2cms_in_stage.sv
// Input register stage that holds one request transaction for the sequencer core.
module i2cms_in_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [i2cms_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [i2cms_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                             take,
   output logic                             item_valid,
   output i2cms_pkg::req_item_type          item
);
   import i2cms_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.action      <= action_type'(req_tuser[1:0]);
         item_ff.target_addr <= req_tdata[7:0];
         item_ff.xfer_length <= req_tdata[23:8];
         item_ff.start_flag  <= req_tdata[24];
         item_ff.addr_flag   <= req_tdata[25];
         item_ff.nack_flag   <= req_tdata[26];
         item_ff.tx_empty    <= req_tdata[27];
         item_ff.rx_ready    <= req_tdata[28];
         item_ff.rx_data     <= req_tdata[36:29];
         item_ff.tx_byte     <= req_tdata[44:37];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: design/i2cms_seq_core.sv
// Transfer state machine that turns one request or poll into one command set.
module i2cms_seq_core #(
   parameter int LEN_BITS = i2cms_pkg::LEN_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  i2cms_pkg::req_item_type item,
   output i2cms_pkg::rsp_item_type result
);
   import i2cms_pkg::*;

   localparam int CopyBits = (LEN_BITS < 16) ? LEN_BITS : 16;
   localparam logic [LEN_BITS-1:0] LenOne = LEN_BITS'(1);

   top_phase_type       top_phase_ff, top_phase_in;
   sub_phase_type       sub_phase_ff, sub_phase_in;
   logic [7:0]          slave_addr_ff, slave_addr_in;
   logic [LEN_BITS-1:0] total_len_ff, total_len_in;
   logic [LEN_BITS-1:0] done_count_ff, done_count_in;
   logic [LEN_BITS-1:0] tlen;
   logic [LEN_BITS-1:0] count_inc;
   logic [LEN_BITS-1:0] pos;
   logic                fin;
   status_type          fin_status;

   assign count_inc = done_count_ff + LenOne;

   always_comb begin
      tlen = '0;
      tlen[CopyBits-1:0] = item.xfer_length[CopyBits-1:0];
   end

   always_comb begin
      top_phase_in  = top_phase_ff;
      sub_phase_in  = sub_phase_ff;
      slave_addr_in = slave_addr_ff;
      total_len_in  = total_len_ff;
      done_count_in = done_count_ff;
      fin           = 1'b0;
      fin_status    = STAT_OK;
      result        = '0;
      case (item.action)
         ACT_WRITE, ACT_READ: begin
            if (top_phase_ff == TOP_IDLE && sub_phase_ff == SUB_IDLE && tlen != '0) begin
               result.accepted = 1'b1;
               slave_addr_in   = item.target_addr;
               total_len_in    = tlen;
               done_count_in   = '0;
               top_phase_in    = (item.action == ACT_WRITE) ? TOP_WRITE : TOP_READ;
               sub_phase_in    = SUB_START;
            end
         end
         ACT_POLL: begin
            case (top_phase_ff)
               TOP_INIT: begin
                  top_phase_in = TOP_IDLE;
                  sub_phase_in = SUB_IDLE;
               end
               TOP_WRITE: begin
                  case (sub_phase_ff)
                     SUB_START: begin
                        result.ack_ctrl  = ACK_ENABLE;
                        result.gen_start = 1'b1;
                        sub_phase_in     = SUB_ADDR;
                     end
                     SUB_ADDR: begin
                        if (item.start_flag) begin
                           result.write_valid = 1'b1;
                           result.write_byte  = slave_addr_ff;
                           sub_phase_in       = SUB_CHECK;
                        end
                     end
                     SUB_CHECK: begin
                        if (item.addr_flag) begin
                           result.clear_addr = 1'b1;
                           done_count_in     = '0;
                           if (item.nack_flag) begin
                              result.gen_stop   = 1'b1;
                              result.clear_nack = 1'b1;
                              fin               = 1'b1;
                              fin_status        = STAT_ERR;
                           end else begin
                              sub_phase_in = SUB_DATA;
                           end
                        end
                     end
                     SUB_DATA: begin
                        result.write_valid = 1'b1;
                        result.write_byte  = item.tx_byte;
                        done_count_in      = count_inc;
                        sub_phase_in       = SUB_WAIT;
                     end
                     SUB_WAIT: begin
                        if (!item.tx_empty) begin
                           if (item.nack_flag) begin
                              result.gen_stop   = 1'b1;
                              result.clear_nack = 1'b1;
                              fin               = 1'b1;
                              fin_status        = STAT_ERR;
                           end
                        end else if (done_count_ff == total_len_ff) begin
                           result.gen_stop = 1'b1;
                           fin             = 1'b1;
                        end else begin
                           sub_phase_in = SUB_DATA;
                        end
                     end
                     SUB_IDLE: begin
                        fin = 1'b1;
                     end
                     default: begin
                        fin        = 1'b1;
                        fin_status = STAT_ERR;
                     end
                  endcase
               end
               TOP_READ: begin
                  case (sub_phase_ff)
                     SUB_START: begin
                        result.ack_ctrl  = ACK_ENABLE;
                        result.gen_start = 1'b1;
                        sub_phase_in     = SUB_ADDR;
                     end
                     SUB_ADDR: begin
                        if (item.start_flag) begin
                           result.write_valid = 1'b1;
                           result.write_byte  = slave_addr_ff | READ_BIT;
                           sub_phase_in       = SUB_CHECK;
                        end
                     end
                     SUB_CHECK: begin
                        if (item.addr_flag) begin
                           result.clear_addr = 1'b1;
                           if (total_len_ff == LenOne) begin
                              result.ack_ctrl = ACK_DISABLE;
                              result.gen_stop = 1'b1;
                           end
                           done_count_in = '0;
                           sub_phase_in  = SUB_DATA;
                        end
                     end
                     SUB_DATA: begin
                        if (item.rx_ready) begin
                           result.store_valid = 1'b1;
                           result.store_byte  = item.rx_data;
                           done_count_in      = count_inc;
                           if (count_inc == total_len_ff) begin
                              fin = 1'b1;
                           end else if (count_inc == total_len_ff - LenOne) begin
                              result.ack_ctrl = ACK_DISABLE;
                              result.gen_stop = 1'b1;
                           end
                        end
                     end
                     SUB_IDLE: begin
                        fin = 1'b1;
                     end
                     default: begin
                        fin        = 1'b1;
                        fin_status = STAT_ERR;
                     end
                  endcase
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      if (fin) begin
         top_phase_in  = TOP_IDLE;
         sub_phase_in  = SUB_IDLE;
         result.status = fin_status;
      end else if (top_phase_in == TOP_IDLE) begin
         result.status = STAT_IDLE;
      end else begin
         result.status = STAT_BUSY;
      end

      pos = result.store_valid ? done_count_ff : done_count_in;
      result.byte_pos = '0;
      result.byte_pos[CopyBits-1:0] = pos[CopyBits-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_phase_ff  <= TOP_INIT;
         sub_phase_ff  <= SUB_IDLE;
         slave_addr_ff <= '0;
         total_len_ff  <= '0;
         done_count_ff <= '0;
      end else if (step) begin
         top_phase_ff  <= top_phase_in;
         sub_phase_ff  <= sub_phase_in;
         slave_addr_ff <= slave_addr_in;
         total_len_ff  <= total_len_in;
         done_count_ff <= done_count_in;
      end
   end

endmodule

// File: design/i2cms_out_stage.sv
// Result register that holds one response transaction until the sink takes it.
module i2cms_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  i2cms_pkg::rsp_item_type           result,
   output logic                              slot_free,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [i2cms_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import i2cms_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      if (step) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, result_ff.byte_pos, result_ff.store_byte,
                        result_ff.store_valid, result_ff.clear_addr, result_ff.clear_nack,
                        result_ff.write_byte, result_ff.write_valid, result_ff.gen_stop,
                        result_ff.gen_start, result_ff.ack_ctrl, result_ff.status,
                        result_ff.accepted};

endmodule

// File: design/i2cms_checker.sv
// Port checker for the I2C master transfer sequencer and its bind statement.
module i2cms_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [i2cms_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import i2cms_pkg::*;

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Response valid right after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled response changed.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire ##1 (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("Response missing two cycles after a free transaction.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("Request side stalled without response stall.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[2:1] == STAT_BUSY)
      else $error("Accepted request not reported busy.");

endmodule

bind i2c_master_transfer_sequencer_top i2cms_checker u_i2cms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: dv/tb_top.sv
// Self-checking testbench for the I2C master transfer sequencer top level.
module tb_top;
   import i2cms_pkg::*;

   localparam logic [1:0] ACT_UNUSED    = 2'd3;
   localparam logic [4:0] F_NONE        = 5'b00000;
   localparam logic [4:0] F_START       = 5'b00001;
   localparam logic [4:0] F_ADDR        = 5'b00010;
   localparam logic [4:0] F_NACK        = 5'b00100;
   localparam logic [4:0] F_TXE         = 5'b01000;
   localparam logic [4:0] F_RXR         = 5'b10000;
   localparam int         IDLE_LIMIT    = 3000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         PHASE_ITEMS   = 500;

   typedef struct {
      top_phase_type top;
      sub_phase_type sub;
      logic [7:0]    addr;
      logic [15:0]   total;
      logic [15:0]   count;
   } seq_state_type;

   class xfer_scoreboard;
      rsp_item_type  expected_q[$];
      seq_state_type model;
      int            errors;

      function new();
         model  = reset_state();
         errors = 0;
      endfunction

      static function seq_state_type reset_state();
         seq_state_type st;
         st.top   = TOP_INIT;
         st.sub   = SUB_IDLE;
         st.addr  = '0;
         st.total = '0;
         st.count = '0;
         return st;
      endfunction

      static function rsp_item_type advance(inout seq_state_type st, input req_item_type it);
         rsp_item_type r;
         logic         finished;
         status_type   fin;
         r        = '0;
         finished = 1'b0;
         fin      = STAT_OK;
         case (it.action)
            ACT_WRITE, ACT_READ: begin
               if (st.top == TOP_IDLE && st.sub == SUB_IDLE && it.xfer_length != 0) begin
                  r.accepted = 1'b1;
                  st.addr    = it.target_addr;
                  st.total   = it.xfer_length;
                  st.count   = '0;
                  st.top     = (it.action == ACT_WRITE) ? TOP_WRITE : TOP_READ;
                  st.sub     = SUB_START;
               end
            end
            ACT_POLL: begin
               if (st.top == TOP_INIT) begin
                  st.top = TOP_IDLE;
                  st.sub = SUB_IDLE;
               end else if (st.top == TOP_WRITE) begin
                  case (st.sub)
                     SUB_START: begin
                        r.ack_ctrl  = ACK_ENABLE;
                        r.gen_start = 1'b1;
                        st.sub      = SUB_ADDR;
                     end
                     SUB_ADDR: begin
                        if (it.start_flag) begin
                           r.write_valid = 1'b1;
                           r.write_byte  = st.addr;
                           st.sub        = SUB_CHECK;
                        end
                     end
                     SUB_CHECK: begin
                        if (it.addr_flag) begin
                           r.clear_addr = 1'b1;
                           st.count     = '0;
                           if (it.nack_flag) begin
                              r.gen_stop   = 1'b1;
                              r.clear_nack = 1'b1;
                              finished     = 1'b1;
                              fin          = STAT_ERR;
                           end else begin
                              st.sub = SUB_DATA;
                           end
                        end
                     end
                     SUB_DATA: begin
                        r.write_valid = 1'b1;
                        r.write_byte  = it.tx_byte;
                        st.count      = st.count + 16'd1;
                        st.sub        = SUB_WAIT;
                     end
                     SUB_WAIT: begin
                        if (!it.tx_empty) begin
                           if (it.nack_flag) begin
                              r.gen_stop   = 1'b1;
                              r.clear_nack = 1'b1;
                              finished     = 1'b1;
                              fin          = STAT_ERR;
                           end
                        end else if (st.count == st.total) begin
                           r.gen_stop = 1'b1;
                           finished   = 1'b1;
                           fin        = STAT_OK;
                        end else begin
                           st.sub = SUB_DATA;
                        end
                     end
                     SUB_IDLE: begin
                        finished = 1'b1;
                        fin      = STAT_OK;
                     end
                     default: begin
                        finished = 1'b1;
                        fin      = STAT_ERR;
                     end
                  endcase
               end else if (st.top == TOP_READ) begin
                  case (st.sub)
                     SUB_START: begin
                        r.ack_ctrl  = ACK_ENABLE;
                        r.gen_start = 1'b1;
                        st.sub      = SUB_ADDR;
                     end
                     SUB_ADDR: begin
                        if (it.start_flag) begin
                           r.write_valid = 1'b1;
                           r.write_byte  = st.addr | READ_BIT;
                           st.sub        = SUB_CHECK;
                        end
                     end
                     SUB_CHECK: begin
                        if (it.addr_flag) begin
                           r.clear_addr = 1'b1;
                           if (st.total == 16'd1) begin
                              r.ack_ctrl = ACK_DISABLE;
                              r.gen_stop = 1'b1;
                           end
                           st.count = '0;
                           st.sub   = SUB_DATA;
                        end
                     end
                     SUB_DATA: begin
                        if (it.rx_ready) begin
                           r.store_valid = 1'b1;
                           r.store_byte  = it.rx_data;
                           st.count      = st.count + 16'd1;
                           if (st.count == st.total) begin
                              finished = 1'b1;
                              fin      = STAT_OK;
                           end else if (st.count == st.total - 16'd1) begin
                              r.ack_ctrl = ACK_DISABLE;
                              r.gen_stop = 1'b1;
                           end
                        end
                     end
                     SUB_IDLE: begin
                        finished = 1'b1;
                        fin      = STAT_OK;
                     end
                     default: begin
                        finished = 1'b1;
                        fin      = STAT_ERR;
                     end
                  endcase
               end
            end
            default: ;
         endcase
         if (finished) begin
            st.top   = TOP_IDLE;
            st.sub   = SUB_IDLE;
            r.status = fin;
         end else if (st.top == TOP_IDLE) begin
            r.status = STAT_IDLE;
         end else begin
            r.status = STAT_BUSY;
         end
         r.byte_pos = r.store_valid ? st.count - 16'd1 : st.count;
         return r;
      endfunction

      function void note_request(req_item_type it);
         expected_q.push_back(advance(model, it));
      endfunction

      function void compare(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] d);
         rsp_item_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none, actual %h", $time, d);
            return;
         end
         want = expected_q.pop_front();
         compare("accepted", want.accepted, d[0]);
         compare("status", want.status, d[2:1]);
         compare("ack_ctrl", want.ack_ctrl, d[4:3]);
         compare("gen_start", want.gen_start, d[5]);
         compare("gen_stop", want.gen_stop, d[6]);
         compare("write_valid", want.write_valid, d[7]);
         compare("write_byte", want.write_byte, d[15:8]);
         compare("clear_nack", want.clear_nack, d[16]);
         compare("clear_addr", want.clear_addr, d[17]);
         compare("store_valid", want.store_valid, d[18]);
         compare("store_byte", want.store_byte, d[26:19]);
         compare("byte_pos", want.byte_pos, d[42:27]);
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   xfer_scoreboard sb;
   seq_state_type  gen_state;
   req_item_type   offered;
   int             req_idle_pct  = 0;
   int             rsp_stall_pct = 0;
   int             idle_cycles   = 0;
   bit             hold_off      = 1'b0;

   i2c_master_transfer_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic req_item_type build_item(logic [1:0] act, logic [7:0] ta,
                                                logic [15:0] len, logic [4:0] flags,
                                                logic [7:0] rxd, logic [7:0] txb);
      req_item_type it;
      it.action      = action_type'(act);
      it.target_addr = ta;
      it.xfer_length = len;
      it.start_flag  = flags[0];
      it.addr_flag   = flags[1];
      it.nack_flag   = flags[2];
      it.tx_empty    = flags[3];
      it.rx_ready    = flags[4];
      it.rx_data     = rxd;
      it.tx_byte     = txb;
      return it;
   endfunction

   // Mostly well-formed transfers driven by the shadow state, with some noise mixed in.
   function automatic req_item_type random_item();
      int          pick;
      int          sz;
      int          nack_pct;
      logic [1:0]  act;
      logic [15:0] len;
      logic [4:0]  flags;
      pick  = $urandom_range(99);
      act   = ACT_POLL;
      len   = 16'($urandom);
      flags = 5'($urandom);
      if (gen_state.top == TOP_IDLE && pick < 70) begin
         act = $urandom_range(1) ? ACT_WRITE : ACT_READ;
         sz  = $urandom_range(99);
         if (sz < 3) begin
            len = '0;
         end else if (sz < 85) begin
            len = 16'($urandom_range(6, 1));
         end else if (sz < 97) begin
            len = 16'($urandom_range(40, 7));
         end else begin
            len = 16'($urandom_range(200, 41));
         end
      end else if (pick >= 96) begin
         act = ACT_UNUSED;
      end else if (gen_state.top != TOP_IDLE && pick >= 90) begin
         act = $urandom_range(1) ? ACT_WRITE : ACT_READ;
      end else if (gen_state.top != TOP_IDLE) begin
         nack_pct = (gen_state.top == TOP_WRITE) ? 6 : 40;
         flags[0] = $urandom_range(99) < 70;
         flags[1] = $urandom_range(99) < 70;
         flags[2] = $urandom_range(99) < nack_pct;
         flags[3] = $urandom_range(99) < 70;
         flags[4] = $urandom_range(99) < 70;
      end
      return build_item(act, 8'($urandom), len, flags, 8'($urandom), 8'($urandom));
   endfunction

   task automatic send_item(req_item_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {3'b000, it.tx_byte, it.rx_data, it.rx_ready, it.tx_empty, it.nack_flag,
                     it.addr_flag, it.start_flag, it.xfer_length, it.target_addr};
      offered    <= it;
      void'(xfer_scoreboard::advance(gen_state, it));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) sb.note_request(offered);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      sb        = new();
      gen_state = xfer_scoreboard::reset_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Requests are refused until the first poll leaves the initial phase.
      send_item(build_item(ACT_WRITE, 8'hFF, 16'hFFFF, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_UNUSED, 8'hFF, 16'hFFFF, 5'b11111, 8'hFF, 8'hFF));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_READ, 8'h5A, 16'h0000, F_NONE, 8'h00, 8'h00));
      // Single byte read; the read path ignores a NACK.
      send_item(build_item(ACT_READ, 8'hFE, 16'h0001, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_WRITE, 8'h10, 16'h0004, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_START, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_ADDR | F_NACK, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_RXR, 8'hFF, 8'h00));
      // Longest write, ended early by a NACK while waiting for the transmit register.
      send_item(build_item(ACT_WRITE, 8'h00, 16'hFFFF, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_START, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_ADDR, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'hFF));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_TXE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NACK, 8'h00, 8'h00));
      // Write refused by the slave at the address check.
      send_item(build_item(ACT_WRITE, 8'hA4, 16'h0002, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_NONE, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_START, 8'h00, 8'h00));
      send_item(build_item(ACT_POLL, 8'h00, 16'h0000, F_ADDR | F_NACK, 8'h00, 8'h00));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  hold_off = 1'b1; end
            1: begin req_idle_pct = 70; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 70; end
            default: begin req_idle_pct = 11; rsp_stall_pct = 11; end
         endcase
         repeat (PHASE_ITEMS) send_item(random_item());
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: i2c_master_transfer_sequencer_top.f
design/i2cms_pkg.sv
design/i2cms_in_stage.sv
design/i2cms_seq_core.sv
design/i2cms_out_stage.sv
design/i2c_master_transfer_sequencer_top.sv
design/i2cms_checker.sv
dv/tb_top.sv
